@@ design/pls_pkg.sv @@
`timescale 1ns / 1ps
package pls_pkg;

    // Configuration register map
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_ACCEL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_SCALE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFE_LENGTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_ROWS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_COLS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_POSITION = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_START_VELOCITY = 3'd6;

    // Register reset values
    localparam logic signed [15:0] RST_GRAVITY_ACCEL = -16'sd2509;
    localparam logic [15:0]        RST_GRAVITY_SCALE = 16'd256;
    localparam logic [15:0]        RST_LIFE_LENGTH   = 16'd256;
    localparam logic [4:0]         RST_ATLAS_SIDE    = 5'd1;

    // Square root unit sizes
    localparam int ROOT_W = 34;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int ACC_W  = 67;

    // Datapath operations
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE       = 5'd0;
    localparam logic [OP_W-1:0] OP_CAPTURE    = 5'd1;
    localparam logic [OP_W-1:0] OP_RESTART    = 5'd2;
    localparam logic [OP_W-1:0] OP_GRAV1      = 5'd3;
    localparam logic [OP_W-1:0] OP_GRAV2      = 5'd4;
    localparam logic [OP_W-1:0] OP_VEL_Y      = 5'd5;
    localparam logic [OP_W-1:0] OP_POS_MUL    = 5'd6;
    localparam logic [OP_W-1:0] OP_POS_ADD    = 5'd7;
    localparam logic [OP_W-1:0] OP_SQ_MUL     = 5'd8;
    localparam logic [OP_W-1:0] OP_SQ_ADD     = 5'd9;
    localparam logic [OP_W-1:0] OP_PROG_START = 5'd10;
    localparam logic [OP_W-1:0] OP_TILE_I     = 5'd11;
    localparam logic [OP_W-1:0] OP_ROWCOL_I   = 5'd12;
    localparam logic [OP_W-1:0] OP_ROWCOL_J   = 5'd13;
    localparam logic [OP_W-1:0] OP_U_NOW      = 5'd14;
    localparam logic [OP_W-1:0] OP_V_NOW      = 5'd15;
    localparam logic [OP_W-1:0] OP_U_NEXT     = 5'd16;
    localparam logic [OP_W-1:0] OP_FINISH     = 5'd17;

    typedef struct packed {
        logic               kind;
        logic [15:0]        frame_time;
        logic signed [31:0] camera_x;
        logic signed [31:0] camera_y;
        logic signed [31:0] camera_z;
    } t_in_item;

    typedef struct packed {
        logic               alive;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [32:0]        camera_distance;
        logic [15:0]        tile_u_now;
        logic [15:0]        tile_v_now;
        logic [15:0]        tile_u_next;
        logic [15:0]        tile_v_next;
        logic [15:0]        blend;
    } t_out_item;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } t_cmd;

    typedef struct packed {
        logic is_restart;
        logic axis_last;
        logic div_busy;
        logic sqrt_busy;
        logic out_free;
    } t_stat;

    localparam logic signed [50:0] S32_MAX = 51'sd2147483647;
    localparam logic signed [50:0] S32_MIN = -51'sd2147483648;

    // Clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX) begin
            r = 32'sh7FFFFFFF;
        end else if (v < S32_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ design/pls_ctrl.sv @@
`timescale 1ns / 1ps
module pls_ctrl
    import pls_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    localparam int ST_W = 5;
    localparam logic [ST_W-1:0] S_IDLE = 5'd0;
    localparam logic [ST_W-1:0] S_DISP = 5'd1;
    localparam logic [ST_W-1:0] S_RST  = 5'd2;
    localparam logic [ST_W-1:0] S_G1   = 5'd3;
    localparam logic [ST_W-1:0] S_G2   = 5'd4;
    localparam logic [ST_W-1:0] S_VY   = 5'd5;
    localparam logic [ST_W-1:0] S_PM   = 5'd6;
    localparam logic [ST_W-1:0] S_PA   = 5'd7;
    localparam logic [ST_W-1:0] S_SM   = 5'd8;
    localparam logic [ST_W-1:0] S_SA   = 5'd9;
    localparam logic [ST_W-1:0] S_PS   = 5'd10;
    localparam logic [ST_W-1:0] S_TI   = 5'd11;
    localparam logic [ST_W-1:0] S_RCI  = 5'd12;
    localparam logic [ST_W-1:0] S_RCJ  = 5'd13;
    localparam logic [ST_W-1:0] S_UN   = 5'd14;
    localparam logic [ST_W-1:0] S_VN   = 5'd15;
    localparam logic [ST_W-1:0] S_UX   = 5'd16;
    localparam logic [ST_W-1:0] S_FIN  = 5'd17;

    logic [ST_W-1:0] r_state;
    logic [ST_W-1:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Sequence the operations of one request
    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_CAPTURE;
                    n_state  = S_DISP;
                end
            end
            S_DISP: n_state = i_stat.is_restart ? S_RST : S_G1;
            S_RST: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_RESTART;
                    n_state  = S_IDLE;
                end
            end
            S_G1: begin
                o_cmd.op = OP_GRAV1;
                n_state  = S_G2;
            end
            S_G2: begin
                o_cmd.op = OP_GRAV2;
                n_state  = S_VY;
            end
            S_VY: begin
                o_cmd.op = OP_VEL_Y;
                n_state  = S_PM;
            end
            S_PM: begin
                o_cmd.op = OP_POS_MUL;
                n_state  = S_PA;
            end
            S_PA: begin
                o_cmd.op = OP_POS_ADD;
                n_state  = i_stat.axis_last ? S_SM : S_PM;
            end
            S_SM: begin
                o_cmd.op = OP_SQ_MUL;
                n_state  = S_SA;
            end
            S_SA: begin
                o_cmd.op = OP_SQ_ADD;
                n_state  = i_stat.axis_last ? S_PS : S_SM;
            end
            S_PS: begin
                o_cmd.op = OP_PROG_START;
                n_state  = S_TI;
            end
            S_TI: begin
                if (!i_stat.div_busy && !i_stat.sqrt_busy) begin
                    o_cmd.op = OP_TILE_I;
                    n_state  = S_RCI;
                end
            end
            S_RCI: begin
                if (!i_stat.div_busy) begin
                    o_cmd.op = OP_ROWCOL_I;
                    n_state  = S_RCJ;
                end
            end
            S_RCJ: begin
                if (!i_stat.div_busy) begin
                    o_cmd.op = OP_ROWCOL_J;
                    n_state  = S_UN;
                end
            end
            S_UN: begin
                if (!i_stat.div_busy) begin
                    o_cmd.op = OP_U_NOW;
                    n_state  = S_VN;
                end
            end
            S_VN: begin
                if (!i_stat.div_busy) begin
                    o_cmd.op = OP_V_NOW;
                    n_state  = S_UX;
                end
            end
            S_UX: begin
                if (!i_stat.div_busy) begin
                    o_cmd.op = OP_U_NEXT;
                    n_state  = S_FIN;
                end
            end
            S_FIN: begin
                if (!i_stat.div_busy && i_stat.out_free) begin
                    o_cmd.op = OP_FINISH;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ design/pls_datapath.sv @@
`timescale 1ns / 1ps
module pls_datapath
    import pls_pkg::*;
#(
    parameter int ATLAS_MAX_SIDE = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  t_in_item              i_in_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_out_ready,
    output t_stat                 o_stat,
    output logic                  o_out_valid,
    output t_out_item             o_out_data
);

    localparam int SIDE_W  = $clog2(ATLAS_MAX_SIDE + 1);
    localparam int STAGE_W = 2 * SIDE_W;
    localparam int NUM_W   = 40 + STAGE_W;
    localparam int CNT_W   = $clog2(NUM_W + 1);
    localparam int TQ_W    = SIDE_W + 12;
    localparam int SQC_W   = $clog2(ROOT_W + 1);

    // Configuration registers
    logic signed [15:0] r_gravity_accel;
    logic [15:0]        r_gravity_scale;
    logic [15:0]        r_life_length;
    logic [4:0]         r_atlas_rows;
    logic [4:0]         r_atlas_cols;
    logic [47:0]        r_start_position;
    logic [47:0]        r_start_velocity;

    // Particle state and work registers
    t_in_item           r_in;
    logic signed [31:0] r_pos [3];
    logic signed [31:0] r_vel [3];
    logic [31:0]        r_elapsed;
    logic [1:0]         r_axis;
    logic signed [32:0] r_ga_gs;
    logic signed [49:0] r_grav;
    logic [31+STAGE_W:0] r_num;
    logic signed [48:0] r_prod;
    logic [65:0]        r_sq;
    logic [ACC_W-1:0]   r_acc;
    logic [STAGE_W-1:0] r_j;
    logic [15:0]        r_blend;
    logic [SIDE_W-1:0]  r_row_i;
    logic [SIDE_W-1:0]  r_col_i;
    logic [SIDE_W-1:0]  r_row_j;
    logic [SIDE_W-1:0]  r_col_j;
    logic [15:0]        r_u_now;
    logic [15:0]        r_v_now;
    logic [15:0]        r_u_next;

    // Radix-2 divider and digit-by-digit square root
    logic [NUM_W-1:0]   r_div_w;
    logic [15:0]        r_div_rem;
    logic [15:0]        r_div_den;
    logic [CNT_W-1:0]   r_div_cnt;
    logic [RAD_W-1:0]   r_rad;
    logic [ROOT_W-1:0]  r_root;
    logic [ROOT_W+1:0]  r_rem;
    logic [SQC_W-1:0]   r_sq_cnt;

    t_out_item          r_out;
    logic               r_out_valid;

    logic [SIDE_W-1:0]  rows_c;
    logic [SIDE_W-1:0]  cols_c;
    logic [STAGE_W-1:0] stages;
    logic [STAGE_W-1:0] stages_m1;
    logic [STAGE_W-1:0] i_c;
    logic [STAGE_W-1:0] j_c;
    logic [15:0]        blend_c;
    logic [TQ_W+15:0]   q_ext;
    logic [15:0]        q412_c;
    logic               div_ld;
    logic [NUM_W-1:0]   div_ld_num;
    logic [15:0]        div_ld_den;
    logic [CNT_W-1:0]   div_ld_cnt;
    logic [16:0]        div_r;
    logic               div_ge;
    logic [ROOT_W+3:0]  sq_remt;
    logic [ROOT_W+3:0]  sq_trial;
    logic               sq_ge;
    logic signed [32:0] d_c;
    logic [32:0]        a_c;
    logic [32:0]        e_sum;
    logic [31:0]        e_new;
    logic signed [31:0] ld_pos [3];
    logic signed [31:0] ld_vel [3];
    logic               out_free;

    // Clamp atlas sides to one through the largest side
    always_comb begin
        if (r_atlas_rows == '0) begin
            rows_c = SIDE_W'(1);
        end else if (int'(r_atlas_rows) > ATLAS_MAX_SIDE) begin
            rows_c = SIDE_W'(ATLAS_MAX_SIDE);
        end else begin
            rows_c = SIDE_W'(r_atlas_rows);
        end
        if (r_atlas_cols == '0) begin
            cols_c = SIDE_W'(1);
        end else if (int'(r_atlas_cols) > ATLAS_MAX_SIDE) begin
            cols_c = SIDE_W'(ATLAS_MAX_SIDE);
        end else begin
            cols_c = SIDE_W'(r_atlas_cols);
        end
    end

    assign stages    = STAGE_W'(rows_c) * STAGE_W'(cols_c);
    assign stages_m1 = stages - STAGE_W'(1);

    // Pick tile index and blend from the progress quotient
    always_comb begin
        if (r_life_length == '0) begin
            i_c     = stages_m1;
            blend_c = '0;
        end else begin
            blend_c = r_div_w[15:0];
            if (r_div_w[NUM_W-1:16] > (NUM_W-16)'(stages_m1)) begin
                i_c = stages_m1;
            end else begin
                i_c = r_div_w[16 +: STAGE_W];
            end
        end
        j_c = (i_c < stages_m1) ? i_c + STAGE_W'(1) : i_c;
    end

    // Saturate a tile coordinate quotient to 16 bits
    assign q_ext  = {16'b0, r_div_w[TQ_W-1:0]};
    assign q412_c = (|q_ext[TQ_W+15:16]) ? 16'hFFFF : q_ext[15:0];

    // Divider load per operation, numerator left-aligned
    always_comb begin
        div_ld     = 1'b1;
        div_ld_num = '0;
        div_ld_den = 16'(cols_c);
        div_ld_cnt = CNT_W'(STAGE_W);
        unique case (i_cmd.op)
            OP_PROG_START: begin
                div_ld_num = {r_num, 8'b0};
                div_ld_den = r_life_length;
                div_ld_cnt = CNT_W'(NUM_W);
            end
            OP_TILE_I:   div_ld_num = {i_c, {(NUM_W-STAGE_W){1'b0}}};
            OP_ROWCOL_I: div_ld_num = {r_j, {(NUM_W-STAGE_W){1'b0}}};
            OP_ROWCOL_J: begin
                div_ld_num = {r_col_i, 12'b0, {(NUM_W-TQ_W){1'b0}}};
                div_ld_den = 16'(rows_c);
                div_ld_cnt = CNT_W'(TQ_W);
            end
            OP_U_NOW: begin
                div_ld_num = {r_row_i, 12'b0, {(NUM_W-TQ_W){1'b0}}};
                div_ld_den = 16'(rows_c);
                div_ld_cnt = CNT_W'(TQ_W);
            end
            OP_V_NOW: begin
                div_ld_num = {r_col_j, 12'b0, {(NUM_W-TQ_W){1'b0}}};
                div_ld_den = 16'(rows_c);
                div_ld_cnt = CNT_W'(TQ_W);
            end
            OP_U_NEXT: begin
                div_ld_num = {r_row_j, 12'b0, {(NUM_W-TQ_W){1'b0}}};
                div_ld_den = 16'(rows_c);
                div_ld_cnt = CNT_W'(TQ_W);
            end
            default: div_ld = 1'b0;
        endcase
    end

    assign div_r  = {r_div_rem, r_div_w[NUM_W-1]};
    assign div_ge = (div_r >= {1'b0, r_div_den});

    assign sq_remt  = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign sq_trial = {2'b00, r_root, 2'b01};
    assign sq_ge    = (sq_remt >= sq_trial);

    assign d_c   = 33'(r_in.camera_x) - 33'(r_pos[r_axis]);
    assign a_c   = d_c[32] ? 33'(-d_c) : 33'(d_c);
    assign e_sum = {1'b0, r_elapsed} + 33'(r_in.frame_time);
    assign e_new = e_sum[32] ? 32'hFFFFFFFF : e_sum[31:0];

    // Start values, signed Q8.8 widened to Q16.16
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ld_pos[k] = {{8{r_start_position[16*k+15]}}, r_start_position[16*k +: 16], 8'b0};
            ld_vel[k] = {{8{r_start_velocity[16*k+15]}}, r_start_velocity[16*k +: 16], 8'b0};
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity_accel  <= RST_GRAVITY_ACCEL;
            r_gravity_scale  <= RST_GRAVITY_SCALE;
            r_life_length    <= RST_LIFE_LENGTH;
            r_atlas_rows     <= RST_ATLAS_SIDE;
            r_atlas_cols     <= RST_ATLAS_SIDE;
            r_start_position <= '0;
            r_start_velocity <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRAVITY_ACCEL:  r_gravity_accel  <= i_cfg_data[15:0];
                CFG_GRAVITY_SCALE:  r_gravity_scale  <= i_cfg_data[15:0];
                CFG_LIFE_LENGTH:    r_life_length    <= i_cfg_data[15:0];
                CFG_ATLAS_ROWS:     r_atlas_rows     <= i_cfg_data[4:0];
                CFG_ATLAS_COLS:     r_atlas_cols     <= i_cfg_data[4:0];
                CFG_START_POSITION: r_start_position <= i_cfg_data;
                CFG_START_VELOCITY: r_start_velocity <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Particle state, axis counter and iteration counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_pos[k] <= '0;
                r_vel[k] <= '0;
            end
            r_elapsed   <= '0;
            r_axis      <= '0;
            r_div_cnt   <= '0;
            r_sq_cnt    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Advance the iterative units
            if (div_ld) begin
                r_div_cnt <= div_ld_cnt;
            end else if (r_div_cnt != '0) begin
                r_div_cnt <= r_div_cnt - CNT_W'(1);
            end
            if (i_cmd.op == OP_PROG_START) begin
                r_sq_cnt <= SQC_W'(ROOT_W);
            end else if (r_sq_cnt != '0) begin
                r_sq_cnt <= r_sq_cnt - SQC_W'(1);
            end

            // Drop the result once taken, raise it when formed
            if (i_cmd.op == OP_FINISH || i_cmd.op == OP_RESTART) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (i_cmd.op)
                OP_RESTART: begin
                    for (int k = 0; k < 3; k++) begin
                        r_pos[k] <= ld_pos[k];
                        r_vel[k] <= ld_vel[k];
                    end
                    r_elapsed <= '0;
                end
                OP_VEL_Y: begin
                    r_vel[1] <= sat32(51'(r_vel[1]) + 51'(r_grav >>> 16));
                end
                OP_POS_ADD: begin
                    r_pos[r_axis] <= sat32(51'(r_pos[r_axis]) + 51'(r_prod >>> 16));
                    r_axis        <= (r_axis == 2'd2) ? 2'd0 : r_axis + 2'd1;
                end
                OP_SQ_ADD: begin
                    r_axis <= (r_axis == 2'd2) ? 2'd0 : r_axis + 2'd1;
                end
                OP_FINISH: begin
                    r_elapsed <= e_new;
                end
                default: ;
            endcase
        end
    end

    // Arithmetic work registers
    always_ff @(posedge i_clk) begin
        // Divider step or load
        if (div_ld) begin
            r_div_w   <= div_ld_num;
            r_div_rem <= '0;
            r_div_den <= div_ld_den;
        end else if (r_div_cnt != '0) begin
            r_div_rem <= div_ge ? 16'(div_r - {1'b0, r_div_den}) : div_r[15:0];
            r_div_w   <= {r_div_w[NUM_W-2:0], div_ge};
        end

        // Square root step or load
        if (i_cmd.op == OP_PROG_START) begin
            r_rad  <= {1'b0, r_acc};
            r_root <= '0;
            r_rem  <= '0;
        end else if (r_sq_cnt != '0) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_root <= {r_root[ROOT_W-2:0], sq_ge};
            r_rem  <= sq_ge ? (ROOT_W+2)'(sq_remt - sq_trial) : (ROOT_W+2)'(sq_remt);
        end

        case (i_cmd.op)
            OP_CAPTURE: begin
                r_in  <= i_in_data;
                r_acc <= '0;
            end
            OP_GRAV1: begin
                r_ga_gs <= r_gravity_accel * $signed({1'b0, r_gravity_scale});
                r_num   <= r_elapsed * stages;
            end
            OP_GRAV2: begin
                r_grav <= r_ga_gs * $signed({1'b0, r_in.frame_time});
            end
            OP_POS_MUL: begin
                r_prod <= r_vel[r_axis] * $signed({1'b0, r_in.frame_time});
            end
            OP_SQ_MUL: begin
                r_sq <= 66'(a_c) * 66'(a_c);
                // Rotate the camera coordinates so camera_x holds the next axis
                r_in.camera_x <= r_in.camera_y;
                r_in.camera_y <= r_in.camera_z;
                r_in.camera_z <= r_in.camera_x;
            end
            OP_SQ_ADD: begin
                r_acc <= r_acc + ACC_W'(r_sq);
            end
            OP_TILE_I: begin
                r_j     <= j_c;
                r_blend <= blend_c;
            end
            OP_ROWCOL_I: begin
                r_row_i <= r_div_w[SIDE_W-1:0];
                r_col_i <= r_div_rem[SIDE_W-1:0];
            end
            OP_ROWCOL_J: begin
                r_row_j <= r_div_w[SIDE_W-1:0];
                r_col_j <= r_div_rem[SIDE_W-1:0];
            end
            OP_U_NOW:  r_u_now  <= q412_c;
            OP_V_NOW:  r_v_now  <= q412_c;
            OP_U_NEXT: r_u_next <= q412_c;
            default: ;
        endcase

        // Form the result register
        if (i_cmd.op == OP_RESTART) begin
            r_out.alive           <= (r_life_length != '0);
            r_out.pos_x           <= ld_pos[0];
            r_out.pos_y           <= ld_pos[1];
            r_out.pos_z           <= ld_pos[2];
            r_out.camera_distance <= '0;
            r_out.tile_u_now      <= '0;
            r_out.tile_v_now      <= '0;
            r_out.tile_u_next     <= '0;
            r_out.tile_v_next     <= '0;
            r_out.blend           <= '0;
        end else if (i_cmd.op == OP_FINISH) begin
            r_out.alive           <= (e_new < {r_life_length, 8'b0});
            r_out.pos_x           <= r_pos[0];
            r_out.pos_y           <= r_pos[1];
            r_out.pos_z           <= r_pos[2];
            r_out.camera_distance <= r_root[ROOT_W-1] ? 33'h1FFFFFFFF : r_root[32:0];
            r_out.tile_u_now      <= r_u_now;
            r_out.tile_v_now      <= r_v_now;
            r_out.tile_u_next     <= r_u_next;
            r_out.tile_v_next     <= q412_c;
            r_out.blend           <= r_blend;
        end
    end

    assign o_stat.is_restart = r_in.kind;
    assign o_stat.axis_last  = (r_axis == 2'd2);
    assign o_stat.div_busy   = (r_div_cnt != '0);
    assign o_stat.sqrt_busy  = (r_sq_cnt != '0);
    assign o_stat.out_free   = out_free;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

endmodule

@@ design/particle_life_step.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Signals                                Moves
// in        input      i_in_valid / o_in_ready / i_in_data    tick or restart request
// out       output     o_out_valid / i_out_ready / o_out_data one result per request
// cfg       input      i_cfg_we / i_cfg_idx / i_cfg_data      register write, no wait
//
// A tick is paced by the radix-2 divider: one progress division of
// 40 + 2*SIDE_W steps, two tile index divisions and four tile coordinate
// divisions; the 34-step square root overlaps the progress division.
// Reset (synchronous, active low) loads register defaults and a particle at rest.
// A result waiting in the output register holds the next request at the last step.
module particle_life_step
    import pls_pkg::*;
#(
    parameter int ATLAS_MAX_SIDE = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    pls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    pls_datapath #(
        .ATLAS_MAX_SIDE (ATLAS_MAX_SIDE)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // A result is formed only when the output register is free
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == OP_FINISH || cmd.op == OP_RESTART) |-> stat.out_free)
        else $error("result formed while output register occupied");

    // Tile stage starts only after progress and distance are done
    a_tile_after_iter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == OP_TILE_I) |-> (!stat.div_busy && !stat.sqrt_busy))
        else $error("tile stage started with iteration in flight");

    // One request at a time
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while another is in work");

endmodule
